[src/sfp_pkg.sv]
// Sensor frame parser package: frame geometry, status codes, shared types
// and the field helpers used by the collector and the result stage.
// No dependencies.
package sfp_pkg;

   localparam int FRAME_BYTES = 12;
   localparam int DATA_BYTES  = FRAME_BYTES - 1;   // bytes covered by the checksum
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int FILL_W      = $clog2(FRAME_BYTES);
   localparam int TEMP_SIGN   = WORD_W - 1;

   // first and last stored payload byte (byte 0 is the header, never reported)
   localparam int FIRST_DATA  = 1;
   localparam int LAST_DATA   = DATA_BYTES - 1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   typedef logic [BYTE_W-1:0]        byte_type;
   typedef logic [WORD_W-1:0]        word_type;
   typedef logic signed [WORD_W-1:0] sword_type;
   typedef logic [FILL_W-1:0]        fill_type;

   localparam fill_type FILL_IDLE = '0;
   localparam fill_type FILL_LAST = FILL_W'(DATA_BYTES);

   // one finished frame, handed from the collector to the result stage
   typedef struct packed {
      logic     done;
      logic     ok;
      word_type voc;
      word_type hcho;
      word_type co2;
      word_type temp_word;
      word_type humidity;
   } frame_event_type;

   // collector state flags, used by the top for flow control
   typedef struct packed {
      logic idle;
      logic last_byte;
   } collect_status_type;

   function automatic word_type be16(input byte_type hi, input byte_type lo);
      return {hi, lo};
   endfunction

   // raw with the sign bit set reads as -(0xFFFF - raw), which is raw + 1 mod 2^16
   function automatic sword_type temp_tenths(input word_type raw);
      word_type res;
      res = raw[TEMP_SIGN] ? word_type'(raw + word_type'(1)) : raw;
      return sword_type'(res);
   endfunction

endpackage

[src/sfp_channels.sv]
// Request and response channel interfaces of the sensor frame parser.
// Depends on sfp_pkg for field types.
interface sfp_req_if;
   logic              valid;
   logic              ready;
   sfp_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfp_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   sfp_pkg::word_type  voc_level;
   sfp_pkg::word_type  formaldehyde_level;
   sfp_pkg::word_type  co2_estimate;
   sfp_pkg::sword_type temperature_tenths;
   sfp_pkg::word_type  humidity_tenths;

   modport source (output valid, output status, output voc_level, output formaldehyde_level,
                   output co2_estimate, output temperature_tenths,
                   output humidity_tenths, input ready);
   modport sink (input valid, input status, input voc_level, input formaldehyde_level,
                 input co2_estimate, input temperature_tenths,
                 input humidity_tenths, output ready);
endinterface

[src/sensor_frame_parser_unit.sv]
// Sensor frame parser top: one byte per request, one response per 12-byte frame.
// Depends on sfp_pkg, sfp_channels, sfp_frame_collect and sfp_result_stage.
// Throughput: one request per cycle; only the checksum byte waits, and only while
//   the response register is full and its sink holds ready low.
// Latency: the response is valid the cycle after the checksum byte is accepted.
// Reset (synchronous, active high): partial frame dropped, header register 0, output empty.
module sensor_frame_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  sfp_pkg::byte_type csr_wr_data,
   sfp_req_if.sink           req_if,
   sfp_rsp_if.source         rsp_if
);

   // header byte register, written from the CSR port
   sfp_pkg::byte_type hdr_ff, hdr_in;

   sfp_pkg::frame_event_type    evt;
   sfp_pkg::collect_status_type coll_status;
   logic                        out_free;
   logic                        req_accept;

   assign hdr_in = csr_wr_en ? csr_wr_data : hdr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
      end else begin
         hdr_ff <= hdr_in;
      end
   end

   // Only the checksum byte produces a response, so only it needs room in the
   // response register; every other byte is taken regardless of the sink.
   assign req_if.ready = !coll_status.last_byte || out_free;
   assign req_accept   = req_if.valid && req_if.ready;

   // counter, running sum and byte store
   sfp_frame_collect u_collect (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_if.rx_byte),
      .hdr_value (hdr_ff),
      .evt       (evt),
      .status    (coll_status)
   );

   // field decode and response register
   sfp_result_stage u_result (
      .clock  (clock),
      .reset  (reset),
      .evt    (evt),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

`ifndef NO_ASSERTIONS
   // a checksum failure never leaks readings
   a_mismatch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == sfp_pkg::STATUS_MISMATCH) |->
      (rsp_if.voc_level == '0 && rsp_if.formaldehyde_level == '0 &&
       rsp_if.co2_estimate == '0 && rsp_if.temperature_tenths == '0 &&
       rsp_if.humidity_tenths == '0))
      else $error("mismatch response carries nonzero readings");

   // the checksum byte always yields a response in the next cycle
   a_frame_response: assert property (@(posedge clock) disable iff (reset)
      (req_accept && coll_status.last_byte) |=> rsp_if.valid)
      else $error("checksum byte accepted without a response");

   // temperature mapping never produces the most negative code
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.temperature_tenths != 16'sh8000))
      else $error("temperature out of range");

   // requests are held off only for a checksum byte facing a full output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (coll_status.last_byte && rsp_if.valid && !rsp_if.ready))
      else $error("request stalled without cause");

   // reset leaves the collector hunting for a header
   a_reset_idle: assert property (@(posedge clock)
      reset |=> coll_status.idle)
      else $error("collector not idle after reset");
`endif

endmodule

[src/sfp_frame_collect.sv]
// Frame collector: header hunt, byte counter, running sum and payload store.
// Depends on sfp_pkg.
module sfp_frame_collect (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  sfp_pkg::byte_type            rx_byte,
   input  sfp_pkg::byte_type            hdr_value,
   output sfp_pkg::frame_event_type     evt,
   output sfp_pkg::collect_status_type  status
);

   sfp_pkg::fill_type fill_count_ff, fill_count_in;
   sfp_pkg::byte_type running_sum_ff, running_sum_in;
   sfp_pkg::byte_type data_ff [sfp_pkg::FIRST_DATA:sfp_pkg::LAST_DATA];

   logic is_idle, is_last, store_byte;
   sfp_pkg::byte_type check_sum;

   assign is_idle    = (fill_count_ff == sfp_pkg::FILL_IDLE);
   assign is_last    = (fill_count_ff == sfp_pkg::FILL_LAST);
   assign store_byte = accept && !is_idle && !is_last;

   always_comb begin
      fill_count_in  = fill_count_ff;
      running_sum_in = running_sum_ff;
      if (accept) begin
         if (is_idle) begin
            if (rx_byte == hdr_value) begin
               fill_count_in  = sfp_pkg::fill_type'(1);
               running_sum_in = rx_byte;
            end
         end else if (!is_last) begin
            fill_count_in  = fill_count_ff + sfp_pkg::fill_type'(1);
            running_sum_in = running_sum_ff + rx_byte;
         end else begin
            fill_count_in  = sfp_pkg::FILL_IDLE;
            running_sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff  <= sfp_pkg::FILL_IDLE;
         running_sum_ff <= '0;
      end else begin
         fill_count_ff  <= fill_count_in;
         running_sum_ff <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_byte) begin
         data_ff[fill_count_ff] <= rx_byte;
      end
   end

   // sum plus two's complement of sum wraps to zero
   assign check_sum = running_sum_ff + rx_byte;

   always_comb begin
      evt.done      = accept && is_last;
      evt.ok        = (check_sum == '0);
      evt.voc       = sfp_pkg::be16(data_ff[1], data_ff[2]);
      evt.hcho      = sfp_pkg::be16(data_ff[3], data_ff[4]);
      evt.co2       = sfp_pkg::be16(data_ff[5], data_ff[6]);
      evt.temp_word = sfp_pkg::be16(data_ff[7], data_ff[8]);
      evt.humidity  = sfp_pkg::be16(data_ff[9], data_ff[10]);
   end

   assign status.idle      = is_idle;
   assign status.last_byte = is_last;

endmodule

[src/sfp_result_stage.sv]
// Result stage: decodes a finished frame into the response register.
// Depends on sfp_pkg and sfp_rsp_if.
module sfp_result_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  sfp_pkg::frame_event_type evt,
   output logic                     free,
   sfp_rsp_if.source                rsp_if
);

   logic               valid_ff, valid_in;
   logic               status_ff, status_in;
   sfp_pkg::word_type  voc_ff, voc_in;
   sfp_pkg::word_type  hcho_ff, hcho_in;
   sfp_pkg::word_type  co2_ff, co2_in;
   sfp_pkg::sword_type temp_ff, temp_in;
   sfp_pkg::word_type  hum_ff, hum_in;

   assign free = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      voc_in    = voc_ff;
      hcho_in   = hcho_ff;
      co2_in    = co2_ff;
      temp_in   = temp_ff;
      hum_in    = hum_ff;
      if (evt.done) begin
         valid_in = 1'b1;
         if (evt.ok) begin
            status_in = sfp_pkg::STATUS_OK;
            voc_in    = evt.voc;
            hcho_in   = evt.hcho;
            co2_in    = evt.co2;
            temp_in   = sfp_pkg::temp_tenths(evt.temp_word);
            hum_in    = evt.humidity;
         end else begin
            // bad checksum: report status only, readings forced to zero
            status_in = sfp_pkg::STATUS_MISMATCH;
            voc_in    = '0;
            hcho_in   = '0;
            co2_in    = '0;
            temp_in   = '0;
            hum_in    = '0;
         end
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      voc_ff    <= voc_in;
      hcho_ff   <= hcho_in;
      co2_ff    <= co2_in;
      temp_ff   <= temp_in;
      hum_ff    <= hum_in;
   end

   assign rsp_if.valid              = valid_ff;
   assign rsp_if.status             = status_ff;
   assign rsp_if.voc_level          = voc_ff;
   assign rsp_if.formaldehyde_level = hcho_ff;
   assign rsp_if.co2_estimate       = co2_ff;
   assign rsp_if.temperature_tenths = temp_ff;
   assign rsp_if.humidity_tenths    = hum_ff;

endmodule

[tb/sensor_frame_parser_unit_tb.sv]
// Self-checking testbench for sensor_frame_parser_unit: byte requests in, frame responses out.
// Depends on sfp_pkg, sfp_channels (request/response interfaces) and the parser RTL.
module sensor_frame_parser_unit_tb;

   localparam int HALF_HIGH    = 6;
   localparam int HALF_LOW     = 6;
   localparam int RESET_CYCLES = 8;
   localparam int HOLD_CYCLES  = 90;     // long response hold-off, fills the response register
   localparam int STALL_LIMIT  = 2000;   // cycles with no handshake before the run is abandoned
   localparam int REPORT_MAX   = 10;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 190;

   // one response as seen on the rsp channel
   typedef struct {
      logic               status;
      sfp_pkg::word_type  voc;
      sfp_pkg::word_type  hcho;
      sfp_pkg::word_type  co2;
      sfp_pkg::sword_type temp;
      sfp_pkg::word_type  hum;
   } reading_type;

   // Frame predictor plus the queue of responses it still expects.
   class frame_scoreboard;
      sfp_pkg::byte_type header;
      int unsigned       fill;
      sfp_pkg::byte_type sum;
      sfp_pkg::byte_type held[sfp_pkg::DATA_BYTES];
      reading_type       expected_readings[$];
      int unsigned       mismatches;

      function new();
         header     = '0;
         fill       = 0;
         sum        = '0;
         mismatches = 0;
      endfunction

      // -(0xFFFF - raw) for raw with bit 15 set, raw itself otherwise
      function sfp_pkg::sword_type temp_from_raw(sfp_pkg::word_type raw);
         int mag;
         if (raw[sfp_pkg::WORD_W-1]) begin
            mag = 32'hFFFF - int'(raw);
            return sfp_pkg::sword_type'(-mag);
         end
         return sfp_pkg::sword_type'(raw);
      endfunction

      function void note_request(sfp_pkg::byte_type b);
         reading_type       r;
         sfp_pkg::byte_type want;
         if (fill == 0) begin
            if (b == header) begin
               held[0] = b;
               sum     = b;
               fill    = 1;
            end
            return;
         end
         if (fill < sfp_pkg::DATA_BYTES) begin
            held[fill] = b;
            sum        = sum + b;
            fill++;
            return;
         end
         // checksum byte closes the frame
         want = sfp_pkg::byte_type'(8'd0 - sum);
         fill = 0;
         sum  = '0;
         if (b != want) begin
            r.status = sfp_pkg::STATUS_MISMATCH;
            r.voc    = '0;
            r.hcho   = '0;
            r.co2    = '0;
            r.temp   = '0;
            r.hum    = '0;
         end else begin
            r.status = sfp_pkg::STATUS_OK;
            r.voc    = {held[1], held[2]};
            r.hcho   = {held[3], held[4]};
            r.co2    = {held[5], held[6]};
            r.temp   = temp_from_raw({held[7], held[8]});
            r.hum    = {held[9], held[10]};
         end
         expected_readings.insert(expected_readings.size(), r);
      endfunction

      function void check_response(reading_type got);
         reading_type want;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected response: st=%0b voc=%h hcho=%h co2=%h temp=%0d hum=%h",
                        got.status, got.voc, got.hcho, got.co2, got.temp, got.hum);
            return;
         end
         want = expected_readings.pop_front();
         if (got.status !== want.status || got.voc !== want.voc || got.hcho !== want.hcho ||
             got.co2 !== want.co2 || got.temp !== want.temp || got.hum !== want.hum) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display({"response mismatch: exp st=%0b voc=%h hcho=%h co2=%h temp=%0d hum=%h",
                         " | got st=%0b voc=%h hcho=%h co2=%h temp=%0d hum=%h"},
                        want.status, want.voc, want.hcho, want.co2, want.temp, want.hum,
                        got.status, got.voc, got.hcho, got.co2, got.temp, got.hum);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   sfp_pkg::byte_type csr_wr_data;

   sfp_req_if req_if();
   sfp_rsp_if rsp_if();

   sensor_frame_parser_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   frame_scoreboard sb = new();

   bit                quiet;          // last part of the run: no idling on either side
   bit                long_hold;      // raised by the stimulus, cleared by the receiver
   int unsigned       stall_cycles;
   logic              took;
   reading_type       seen;
   sfp_pkg::byte_type frame_buf[sfp_pkg::FRAME_BYTES];

   // clock: low phase then high phase
   initial clock = 1'b0;
   always begin
      #HALF_LOW  clock = 1'b1;
      #HALF_HIGH clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. The response is
   // checked first; it always belongs to a request noted on an earlier edge.
   // The watchdog counts edges on which no handshake happened at all.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         took = 1'b0;
         if (rsp_if.valid && rsp_if.ready) begin
            seen.status = rsp_if.status;
            seen.voc    = rsp_if.voc_level;
            seen.hcho   = rsp_if.formaldehyde_level;
            seen.co2    = rsp_if.co2_estimate;
            seen.temp   = rsp_if.temperature_tenths;
            seen.hum    = rsp_if.humidity_tenths;
            sb.check_response(seen);
            took = 1'b1;
         end
         if (req_if.valid && req_if.ready) begin
            sb.note_request(req_if.rx_byte);
            took = 1'b1;
         end
         if (took)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: ready changes only at the falling edge, at most one update
   // per edge. Short random holds, or one long hold when the stimulus asks
   // for it (the parser then has to stall the checksum byte).
   // ------------------------------------------------------------------
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Sender tasks. All of them start and end at a falling edge. valid is
   // left high between back-to-back requests, so it is never lowered and
   // raised in the same step.
   // ------------------------------------------------------------------
   task automatic send_byte(input sfp_pkg::byte_type b);
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // random request-side bubble, never in the quiet tail
   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic send_span(input int first, input int last);
      for (int i = first; i <= last; i++) begin
         maybe_gap();
         send_byte(frame_buf[i]);
      end
   endtask

   // checksum byte = two's complement of the sum of bytes 0..10; flip bits to break it
   task automatic seal_frame(input bit corrupt);
      sfp_pkg::byte_type s;
      s = '0;
      for (int i = 0; i < sfp_pkg::DATA_BYTES; i++) s = s + frame_buf[i];
      frame_buf[sfp_pkg::DATA_BYTES] = sfp_pkg::byte_type'(8'd0 - s);
      if (corrupt)
         frame_buf[sfp_pkg::DATA_BYTES] ^= sfp_pkg::byte_type'($urandom_range(1, 255));
   endtask

   // random payload; temperature bytes favor the sign-boundary patterns
   task automatic build_random_frame(input sfp_pkg::byte_type hdr);
      sfp_pkg::word_type raw;
      frame_buf[0] = hdr;
      for (int i = 1; i < sfp_pkg::DATA_BYTES; i++)
         frame_buf[i] = ($urandom_range(0, 9) == 0) ? hdr : sfp_pkg::byte_type'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 4))
            0:       raw = 16'h0000;
            1:       raw = 16'h7FFF;
            2:       raw = 16'h8000;
            3:       raw = 16'h8001;
            default: raw = 16'hFFFF;
         endcase
         frame_buf[7] = raw[15:8];
         frame_buf[8] = raw[7:0];
      end
      seal_frame($urandom_range(0, 4) == 0);
   endtask

   // quiesce the pipe: nothing offered, nothing pending, then the latency margin
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.expected_readings.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // header register write; only called with the pipe drained
   task automatic write_header(input sfp_pkg::byte_type h);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= h;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.header = h;
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int                count;
      int                pick;
      sfp_pkg::byte_type hdr;

      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_if.valid       = 1'b0;
      req_if.rx_byte     = '0;
      rsp_if.ready       = 1'b0;
      quiet              = 1'b0;
      long_hold          = 1'b0;
      stall_cycles       = 0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed. Header is still at its reset value of zero: a stray byte is
      // dropped, then a good frame whose payload carries the header value,
      // all-ones voc, and the most negative temperature pattern.
      send_byte(8'h5A);
      frame_buf = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h12, 8'h34,
                    8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00};
      seal_frame(1'b0);
      send_span(0, sfp_pkg::FRAME_BYTES - 1);
      drain();

      // Header moved to all-ones; the register is changed again halfway through
      // the frame, which must not disturb it. The checksum is broken, so the
      // response carries the mismatch status with zeroed readings.
      write_header(8'hFF);
      frame_buf = '{8'hFF, 8'hFF, 8'h00, 8'h01, 8'h80, 8'hFF, 8'hFF,
                    8'hFF, 8'hFF, 8'hC3, 8'h3C, 8'h00};
      seal_frame(1'b1);
      send_span(0, 5);
      drain();
      write_header(8'h3C);
      send_span(6, sfp_pkg::FRAME_BYTES - 1);
      drain();

      // Random phases, each with its own header value.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       hdr = 8'h00;
            1:       hdr = 8'hFF;
            3:       hdr = 8'hA5;
            default: hdr = sfp_pkg::byte_type'($urandom);
         endcase
         write_header(hdr);
         if (phase == PHASES - 1) quiet = 1'b1;
         // one long response hold while frames keep coming
         if (phase == 2) long_hold = 1'b1;
         count = 0;
         while (count < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               // complete any frame left open by a broken sequence first
               while (sb.fill != 0) begin
                  maybe_gap();
                  send_byte(sfp_pkg::byte_type'($urandom));
                  count++;
               end
               build_random_frame(hdr);
               send_span(0, sfp_pkg::FRAME_BYTES - 1);
               count += sfp_pkg::FRAME_BYTES;
            end else if (pick < 88) begin
               // line noise; a value that happens to match opens a frame
               repeat ($urandom_range(1, 3)) begin
                  maybe_gap();
                  send_byte(sfp_pkg::byte_type'($urandom));
                  count++;
               end
            end else begin
               // truncated frame: the following bytes get absorbed into it
               build_random_frame(hdr);
               pick = $urandom_range(1, sfp_pkg::DATA_BYTES);
               send_span(0, pick - 1);
               count += pick;
            end
         end
         drain();
      end

      // settle: nothing pending, then a further wait for stray responses
      drain();
      repeat (8) @(negedge clock);
      if (sb.mismatches == 0 && sb.expected_readings.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
src/sfp_pkg.sv
src/sfp_channels.sv
src/sfp_frame_collect.sv
src/sfp_result_stage.sv
src/sensor_frame_parser_unit.sv
tb/sensor_frame_parser_unit_tb.sv
